[sv/sbm_pkg.sv]
// ----------------------------------------------------------------------------
// Serial bank mapper package
// Shared types and codes for the bus classifier, the queue and the executor.
// ----------------------------------------------------------------------------
package sbm_pkg;

  localparam logic [2:0] FUNC_TICK      = 3'd0;
  localparam logic [2:0] FUNC_CPU_READ  = 3'd1;
  localparam logic [2:0] FUNC_CPU_WRITE = 3'd2;
  localparam logic [2:0] FUNC_PPU_READ  = 3'd3;
  localparam logic [2:0] FUNC_PPU_WRITE = 3'd4;

  localparam logic [2:0] TGT_NONE    = 3'd0;
  localparam logic [2:0] TGT_PRG_ROM = 3'd1;
  localparam logic [2:0] TGT_PRG_RAM = 3'd2;
  localparam logic [2:0] TGT_CHR_ROM = 3'd3;
  localparam logic [2:0] TGT_CHR_RAM = 3'd4;
  localparam logic [2:0] TGT_NT_RAM  = 3'd5;

  localparam logic [2:0] KIND_SNROM = 3'd1;
  localparam logic [2:0] KIND_SOROM = 3'd2;
  localparam logic [2:0] KIND_SUROM = 3'd3;
  localparam logic [2:0] KIND_SXROM = 3'd4;

  localparam logic [1:0] CFG_BOARD_KIND  = 2'd0;
  localparam logic [1:0] CFG_HAS_CHR_ROM = 2'd1;
  localparam logic [1:0] CFG_HAS_CHR_RAM = 2'd2;

  localparam logic [1:0] REG_CONTROL  = 2'd0;
  localparam logic [1:0] REG_CHR_LOW  = 2'd1;
  localparam logic [1:0] REG_CHR_HIGH = 2'd2;
  localparam logic [1:0] REG_PRG      = 2'd3;

  localparam logic [1:0] HOLD_TICKS = 2'd2;
  localparam logic [2:0] SHIFT_LAST = 3'd4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TICK,
    OP_OPEN_READ,
    OP_PLAIN_WRITE,
    OP_WRAM_READ,
    OP_WRAM_WRITE,
    OP_PRG_READ,
    OP_PORT_WRITE,
    OP_NT_READ,
    OP_NT_WRITE,
    OP_CHR_READ,
    OP_CHR_WRITE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] address;
    logic [7:0]  data;
  } entry_t;

  typedef struct packed {
    logic [2:0] board_kind;
    logic       has_chr_rom;
    logic       has_chr_ram;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [18:0] mem_address;
    logic        mem_write;
    logic [7:0]  bus_data;
  } result_t;

endpackage

[sv/serial_bank_mapper.sv]
// ----------------------------------------------------------------------------
// Serial bank mapper
// Cartridge bank controller with a five-bit serial load port.
// ----------------------------------------------------------------------------
// Each input transaction is one bus event (tick, CPU read or write, PPU read
// or write) given by func, address and data_in. Each produces exactly one
// output transaction naming the target memory, the translated address, the
// write strobe and the bus data.
// The board variant and fitted character memories are set through the
// configuration write port; the user writes it only while the block is idle,
// which the block does not enforce. An accepted transaction enters a short
// queue after classification; the executor takes one queue entry per cycle
// unless the output stalls, updates the banking registers and loads the
// result register. The block sustains one transaction per cycle unless stalled.
// When the receiver stalls, the result register holds and the queue absorbs
// up to QUEUE_DEPTH further transactions before in_ready drops.
// Reset clears the queue and output and restores the power-on bank state.
// ----------------------------------------------------------------------------
module serial_bank_mapper #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [15:0] address,
  input  logic [7:0]  data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  target,
  output logic [18:0] mem_address,
  output logic        mem_write,
  output logic [7:0]  bus_data
);
  import sbm_pkg::*;

  cfg_t    cfg;
  entry_t  push_entry;
  entry_t  head_entry;
  result_t result;
  logic    push;
  logic    queue_full;
  logic    pop;
  logic    head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOARD_KIND:  cfg.board_kind <= cfg_wdata;
        CFG_HAS_CHR_ROM: cfg.has_chr_rom <= cfg_wdata[0];
        CFG_HAS_CHR_RAM: cfg.has_chr_ram <= cfg_wdata[0];
        default: cfg <= cfg;
      endcase
    end
  end

  sbm_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .address    (address),
    .data_in    (data_in),
    .push       (push),
    .entry      (push_entry),
    .queue_full (queue_full)
  );

  sbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  sbm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign target      = result.target;
  assign mem_address = result.mem_address;
  assign mem_write   = result.mem_write;
  assign bus_data    = result.bus_data;

  a_write_has_target : assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_write |-> target != TGT_NONE)
    else $error("memory write without a target");

  a_none_zero_address : assert property (@(posedge clk) disable iff (rst)
    out_valid && target == TGT_NONE |-> mem_address == '0 && !mem_write)
    else $error("nonzero address without a target");

  a_full_only_on_stall : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("queue filled without an output stall");

endmodule

[sv/sbm_front.sv]
// ----------------------------------------------------------------------------
// Serial bank mapper bus classifier
// Decodes each incoming bus transaction into an operation for the executor.
// ----------------------------------------------------------------------------
module sbm_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      func,
  input  logic [15:0]     address,
  input  logic [7:0]      data_in,
  output logic            push,
  output sbm_pkg::entry_t entry,
  input  logic            queue_full
);
  import sbm_pkg::*;

  op_t op;
  logic wram_window;

  assign wram_window = (address[15:13] == 3'b011);

  always_comb begin
    unique case (func)
      FUNC_TICK: op = OP_TICK;
      FUNC_CPU_READ: begin
        if (wram_window) op = OP_WRAM_READ;
        else if (address[15]) op = OP_PRG_READ;
        else op = OP_OPEN_READ;
      end
      FUNC_CPU_WRITE: begin
        if (wram_window) op = OP_WRAM_WRITE;
        else if (address[15]) op = OP_PORT_WRITE;
        else op = OP_PLAIN_WRITE;
      end
      FUNC_PPU_READ: op = address[13] ? OP_NT_READ : OP_CHR_READ;
      FUNC_PPU_WRITE: op = address[13] ? OP_NT_WRITE : OP_CHR_WRITE;
      default: op = OP_NOP;
    endcase
  end

  assign in_ready      = !queue_full;
  assign push          = in_valid && !queue_full;
  assign entry.op      = op;
  assign entry.address = address;
  assign entry.data    = data_in;

endmodule

[sv/sbm_queue.sv]
// ----------------------------------------------------------------------------
// Serial bank mapper operation queue
// Small FIFO that decouples the classifier from the executor.
// ----------------------------------------------------------------------------
module sbm_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sbm_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output sbm_pkg::entry_t head_entry
);
  import sbm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_COUNT);
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/sbm_back.sv]
// ----------------------------------------------------------------------------
// Serial bank mapper executor
// Holds the banking registers, runs the serial load port and translates each
// access into a target memory and address, one operation per unstalled cycle.
// ----------------------------------------------------------------------------
module sbm_back (
  input  logic             clk,
  input  logic             rst,
  input  sbm_pkg::cfg_t    cfg,
  input  logic             head_valid,
  input  sbm_pkg::entry_t  head_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output sbm_pkg::result_t result
);
  import sbm_pkg::*;

  logic [1:0] write_hold, write_hold_next;
  logic [2:0] shift_count, shift_count_next;
  logic [4:0] shift_bits, shift_bits_next;
  logic [1:0] mirror_select, mirror_select_next;
  logic       prg_fixed_slot, prg_fixed_slot_next;
  logic       prg_half_mode, prg_half_mode_next;
  logic       chr_half_mode, chr_half_mode_next;
  logic [4:0] chr_bank_low, chr_bank_low_next;
  logic [4:0] chr_bank_high, chr_bank_high_next;
  logic [3:0] prg_bank, prg_bank_next;
  logic       wram_off, wram_off_next;

  logic [15:0] a;
  logic [7:0]  d;
  logic        wram_blocked;
  logic        outer_bank;
  logic [3:0]  prg_bank4;
  logic [4:0]  prg_bank5;
  logic [1:0]  ram_bank;
  logic [4:0]  chr_bank;
  logic        nt_page;
  logic [18:0] prg_rom_addr;
  logic [18:0] prg_ram_addr;
  logic [18:0] chr_addr;
  logic [18:0] nt_addr;
  logic [4:0]  shifted;
  result_t     res;

  assign a   = head_entry.address;
  assign d   = head_entry.data;
  assign pop = head_valid && (!out_valid || out_ready);

  assign wram_blocked = (cfg.board_kind == KIND_SNROM) && chr_bank_low[4];
  assign outer_bank   = (cfg.board_kind == KIND_SUROM) || (cfg.board_kind == KIND_SXROM);

  always_comb begin
    if (prg_half_mode) begin
      if (a[14] != prg_fixed_slot) prg_bank4 = prg_bank;
      else prg_bank4 = a[14] ? 4'hf : 4'h0;
    end else begin
      prg_bank4 = {prg_bank[3:1], a[14]};
    end
    prg_bank5 = {outer_bank ? chr_bank_low[4] : 1'b0, prg_bank4};

    if (cfg.board_kind == KIND_SOROM) ram_bank = {1'b0, chr_bank_low[3]};
    else if (outer_bank) ram_bank = chr_bank_low[3:2];
    else ram_bank = 2'b00;

    if (chr_half_mode) chr_bank = a[12] ? chr_bank_high : chr_bank_low;
    else chr_bank = {chr_bank_low[4:1], a[12]};

    unique case (mirror_select)
      2'd0: nt_page = 1'b0;
      2'd1: nt_page = 1'b1;
      2'd2: nt_page = a[10];
      default: nt_page = a[11];
    endcase
  end

  assign prg_rom_addr = {prg_bank5, a[13:0]};
  assign prg_ram_addr = {4'b0000, ram_bank, a[12:0]};
  assign chr_addr     = {2'b00, chr_bank, a[11:0]};
  assign nt_addr      = {8'h00, nt_page, a[9:0]};

  always_comb begin
    res = '0;
    unique case (head_entry.op)
      OP_OPEN_READ: res.bus_data = d;
      OP_PLAIN_WRITE, OP_PORT_WRITE: res.bus_data = d;
      OP_WRAM_READ: begin
        if (wram_blocked) begin
          res.bus_data = d;
        end else if (!wram_off) begin
          res.target      = TGT_PRG_RAM;
          res.mem_address = prg_ram_addr;
        end
      end
      OP_WRAM_WRITE: begin
        res.bus_data = d;
        if (!wram_blocked && !wram_off) begin
          res.target      = TGT_PRG_RAM;
          res.mem_address = prg_ram_addr;
          res.mem_write   = 1'b1;
        end
      end
      OP_PRG_READ: begin
        res.target      = TGT_PRG_ROM;
        res.mem_address = prg_rom_addr;
      end
      OP_NT_READ: begin
        res.target      = TGT_NT_RAM;
        res.mem_address = nt_addr;
      end
      OP_NT_WRITE: begin
        res.target      = TGT_NT_RAM;
        res.mem_address = nt_addr;
        res.mem_write   = 1'b1;
        res.bus_data    = d;
      end
      OP_CHR_READ: begin
        if (cfg.has_chr_rom) begin
          res.target      = TGT_CHR_ROM;
          res.mem_address = chr_addr;
        end else if (cfg.has_chr_ram) begin
          res.target      = TGT_CHR_RAM;
          res.mem_address = chr_addr;
        end else begin
          res.bus_data = d;
        end
      end
      OP_CHR_WRITE: begin
        res.bus_data = d;
        if (cfg.has_chr_ram) begin
          res.target      = TGT_CHR_RAM;
          res.mem_address = chr_addr;
          res.mem_write   = 1'b1;
        end
      end
      default: res = '0;
    endcase
  end

  assign shifted = {d[0], shift_bits[4:1]};

  always_comb begin
    write_hold_next     = write_hold;
    shift_count_next    = shift_count;
    shift_bits_next     = shift_bits;
    mirror_select_next  = mirror_select;
    prg_fixed_slot_next = prg_fixed_slot;
    prg_half_mode_next  = prg_half_mode;
    chr_half_mode_next  = chr_half_mode;
    chr_bank_low_next   = chr_bank_low;
    chr_bank_high_next  = chr_bank_high;
    prg_bank_next       = prg_bank;
    wram_off_next       = wram_off;
    if (head_entry.op == OP_TICK) begin
      if (write_hold != 2'd0) write_hold_next = write_hold - 1'b1;
    end else if (head_entry.op == OP_PORT_WRITE && write_hold == 2'd0) begin
      write_hold_next = HOLD_TICKS;
      if (d[7]) begin
        shift_count_next    = '0;
        prg_half_mode_next  = 1'b1;
        prg_fixed_slot_next = 1'b1;
      end else begin
        shift_bits_next = shifted;
        if (shift_count == SHIFT_LAST) begin
          shift_count_next = '0;
          unique case (a[14:13])
            REG_CONTROL: begin
              mirror_select_next  = shifted[1:0];
              prg_fixed_slot_next = shifted[2];
              prg_half_mode_next  = shifted[3];
              chr_half_mode_next  = shifted[4];
            end
            REG_CHR_LOW:  chr_bank_low_next = shifted;
            REG_CHR_HIGH: chr_bank_high_next = shifted;
            REG_PRG: begin
              prg_bank_next = shifted[3:0];
              wram_off_next = shifted[4];
            end
            default: prg_bank_next = prg_bank;
          endcase
        end else begin
          shift_count_next = shift_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_hold     <= '0;
      shift_count    <= '0;
      shift_bits     <= '0;
      mirror_select  <= '0;
      prg_fixed_slot <= 1'b1;
      prg_half_mode  <= 1'b1;
      chr_half_mode  <= 1'b0;
      chr_bank_low   <= 5'd0;
      chr_bank_high  <= 5'd1;
      prg_bank       <= '0;
      wram_off       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        write_hold     <= write_hold_next;
        shift_count    <= shift_count_next;
        shift_bits     <= shift_bits_next;
        mirror_select  <= mirror_select_next;
        prg_fixed_slot <= prg_fixed_slot_next;
        prg_half_mode  <= prg_half_mode_next;
        chr_half_mode  <= chr_half_mode_next;
        chr_bank_low   <= chr_bank_low_next;
        chr_bank_high  <= chr_bank_high_next;
        prg_bank       <= prg_bank_next;
        wram_off       <= wram_off_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= res;
    end
  end

endmodule

[tb/tb_serial_bank_mapper.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial bank mapper testbench
// A directed table covers reset state, field extremes, the register port
// hold-off and the work RAM and pattern memory special cases. Random traffic
// then runs under several board settings: serial register loads, mostly with
// proper tick spacing, mixed with plain bus accesses, port noise, ticks and
// spare function codes. Every output transaction is compared field by field
// against an in-order queue of predicted results.
// ----------------------------------------------------------------------------
module tb_serial_bank_mapper;
  import sbm_pkg::*;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [2:0] KIND_PLAIN = 3'd0;
  localparam logic [2:0] KIND_ALIAS = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 40;
  localparam result_t NO_RESULT = '0;

  typedef enum logic {ROW_ACCESS, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [2:0]  func;
    logic [15:0] addr;
    logic [7:0]  data;
    int          pad;
    logic        known;
    result_t     want;
  } step_t;

  localparam cfg_t BOARDS [8] = '{
    '{KIND_PLAIN, 1'b0, 1'b0}, '{KIND_SNROM, 1'b0, 1'b1},
    '{KIND_SOROM, 1'b1, 1'b0}, '{KIND_SUROM, 1'b1, 1'b1},
    '{KIND_SXROM, 1'b0, 1'b1}, '{KIND_ALIAS, 1'b1, 1'b1},
    '{KIND_SXROM, 1'b1, 1'b0}, '{KIND_SNROM, 1'b1, 1'b1}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [2:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  func = '0;
  logic [15:0] address = '0;
  logic [7:0]  data_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  target;
  logic [18:0] mem_address;
  logic        mem_write;
  logic [7:0]  bus_data;

  serial_bank_mapper dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .address(address), .data_in(data_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .target(target), .mem_address(mem_address),
    .mem_write(mem_write), .bus_data(bus_data)
  );

  always #1 clk = ~clk;

  // Mapper state mirrored by the predictor.
  logic [2:0] kind_cfg = KIND_PLAIN;
  logic       chr_rom_cfg = 1'b0;
  logic       chr_ram_cfg = 1'b0;
  logic [1:0] hold_left = '0;
  logic [2:0] load_count = '0;
  logic [4:0] load_bits = '0;
  logic [1:0] mirror_mode = '0;
  logic       fixed_slot = 1'b1;
  logic       prg16_mode = 1'b1;
  logic       chr4_mode = 1'b0;
  logic [4:0] chr_lo = '0;
  logic [4:0] chr_hi = 5'd1;
  logic [3:0] prg_sel = '0;
  logic       wram_disable = 1'b0;

  result_t pending_results [$];
  result_t head;
  step_t   plan [$];
  int      mismatches = 0;
  int      bus_items = 0;
  int      burst_left = 0;
  int      idle_cycles = 0;
  int      ready_span = 0;
  logic [15:0] ready_pat = '1;

  function automatic logic [18:0] prg_rom_map(input logic [15:0] a);
    logic [4:0] bank;
    bank = {1'b0, prg_sel[3:1], a[14]};
    if (prg16_mode) begin
      bank = a[14] ? 5'h0f : 5'h00;
      if (a[14] != fixed_slot) bank = {1'b0, prg_sel};
    end
    if (kind_cfg == KIND_SUROM || kind_cfg == KIND_SXROM) bank = {chr_lo[4], bank[3:0]};
    return {bank, a[13:0]};
  endfunction

  function automatic logic [18:0] prg_ram_map(input logic [15:0] a);
    logic [1:0] bank;
    bank = '0;
    if (kind_cfg == KIND_SOROM) bank = {1'b0, chr_lo[3]};
    if (kind_cfg == KIND_SUROM || kind_cfg == KIND_SXROM) bank = chr_lo[3:2];
    return {4'b0, bank, a[12:0]};
  endfunction

  function automatic logic [18:0] chr_map(input logic [15:0] a);
    logic [4:0] bank;
    bank = a[12] ? chr_hi : chr_lo;
    if (!chr4_mode) bank = {chr_lo[4:1], a[12]};
    return {2'b0, bank, a[11:0]};
  endfunction

  function automatic logic [18:0] nt_map(input logic [15:0] a);
    case (mirror_mode)
      2'd0: return {9'b0, a[9:0]};
      2'd1: return {8'b0, 1'b1, a[9:0]};
      2'd2: return {8'b0, a[10], a[9:0]};
      default: return {8'b0, a[11], a[9:0]};
    endcase
  endfunction

  function automatic logic wram_cut();
    return kind_cfg == KIND_SNROM && chr_lo[4];
  endfunction

  function automatic void shift_in(input logic [15:0] a, input logic [7:0] d);
    if (hold_left != 0) return;
    hold_left = HOLD_TICKS;
    if (d[7]) begin
      load_count = '0;
      prg16_mode = 1'b1;
      fixed_slot = 1'b1;
      return;
    end
    load_bits = {d[0], load_bits[4:1]};
    load_count = load_count + 3'd1;
    if (load_count <= SHIFT_LAST) return;
    load_count = '0;
    case (a[14:13])
      REG_CONTROL: begin
        mirror_mode = load_bits[1:0];
        fixed_slot = load_bits[2];
        prg16_mode = load_bits[3];
        chr4_mode = load_bits[4];
      end
      REG_CHR_LOW: chr_lo = load_bits;
      REG_CHR_HIGH: chr_hi = load_bits;
      default: begin
        prg_sel = load_bits[3:0];
        wram_disable = load_bits[4];
      end
    endcase
  endfunction

  function automatic result_t map_access(input logic [2:0] f, input logic [15:0] a,
                                         input logic [7:0] d);
    result_t r;
    r = '0;
    case (f)
      FUNC_TICK: if (hold_left != 0) hold_left = hold_left - 2'd1;
      FUNC_CPU_READ: begin
        if (a[15:13] == 3'b011) begin
          if (wram_cut()) r.bus_data = d;
          else if (!wram_disable) begin
            r.target = TGT_PRG_RAM;
            r.mem_address = prg_ram_map(a);
          end
        end else if (a[15]) begin
          r.target = TGT_PRG_ROM;
          r.mem_address = prg_rom_map(a);
        end else begin
          r.bus_data = d;
        end
      end
      FUNC_CPU_WRITE: begin
        r.bus_data = d;
        if (a[15:13] == 3'b011) begin
          if (!wram_cut() && !wram_disable) begin
            r.target = TGT_PRG_RAM;
            r.mem_address = prg_ram_map(a);
            r.mem_write = 1'b1;
          end
        end else if (a[15]) begin
          shift_in(a, d);
        end
      end
      FUNC_PPU_READ: begin
        if (a[13]) begin
          r.target = TGT_NT_RAM;
          r.mem_address = nt_map(a);
        end else if (chr_rom_cfg) begin
          r.target = TGT_CHR_ROM;
          r.mem_address = chr_map(a);
        end else if (chr_ram_cfg) begin
          r.target = TGT_CHR_RAM;
          r.mem_address = chr_map(a);
        end else begin
          r.bus_data = d;
        end
      end
      FUNC_PPU_WRITE: begin
        r.bus_data = d;
        if (a[13]) begin
          r.target = TGT_NT_RAM;
          r.mem_address = nt_map(a);
          r.mem_write = 1'b1;
        end else if (chr_ram_cfg) begin
          r.target = TGT_CHR_RAM;
          r.mem_address = chr_map(a);
          r.mem_write = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic issue(input logic [2:0] f, input logic [15:0] a, input logic [7:0] d,
                       input logic fixed = 1'b0, input result_t fixed_res = '0);
    int gap;
    result_t r;
    cfg_we <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= f;
    address <= a;
    data_in <= d;
    do @(posedge clk); while (!in_ready);
    r = map_access(f, a, d);
    pending_results.push_back(fixed ? fixed_res : r);
    if (f != FUNC_TICK && f < FUNC_SPARE_LO) bus_items++;
  endtask

  task automatic tick_pad(input int n);
    repeat (n) issue(FUNC_TICK, 16'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Leaves the write enable high; the next transaction lowers it.
  task automatic set_reg(input logic [1:0] idx, input logic [2:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_BOARD_KIND: kind_cfg = val;
      CFG_HAS_CHR_ROM: chr_rom_cfg = val[0];
      default: chr_ram_cfg = val[0];
    endcase
  endtask

  task automatic random_access();
    case ($urandom_range(0, 5))
      0: issue(FUNC_CPU_READ, 16'($urandom), 8'($urandom));
      1: issue(FUNC_CPU_WRITE, 16'($urandom) & 16'h7fff, 8'($urandom));
      2: issue(FUNC_PPU_READ, 16'($urandom), 8'($urandom));
      3: issue(FUNC_PPU_WRITE, 16'($urandom), 8'($urandom));
      4: issue(FUNC_CPU_READ, 16'h6000 | (16'($urandom) & 16'h1fff), 8'($urandom));
      default: issue(FUNC_CPU_WRITE, 16'h6000 | (16'($urandom) & 16'h1fff), 8'($urandom));
    endcase
  endtask

  task automatic serial_load();
    int r;
    if ($urandom_range(0, 1) == 1) begin
      issue(FUNC_CPU_WRITE, 16'h8000 | 16'($urandom), 8'h80 | 8'($urandom));
      tick_pad(2);
    end
    repeat (5) begin
      issue(FUNC_CPU_WRITE, 16'h8000 | 16'($urandom), 8'($urandom) & 8'h7f);
      if ($urandom_range(0, 3) == 0) random_access();
      r = $urandom_range(0, 19);
      tick_pad(r == 0 ? 0 : r == 1 ? 1 : r < 5 ? 3 : 2);
    end
    repeat ($urandom_range(0, 4)) random_access();
  endtask

  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_span = $urandom_range(16, 96);
      ready_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
    end
    ready_span--;
    out_ready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[15:1]};
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("output transaction with nothing outstanding");
        mismatches++;
      end else begin
        head = pending_results.pop_front();
        if (target !== head.target) begin
          $error("target: expected %0d, got %0d", head.target, target);
          mismatches++;
        end
        if (mem_address !== head.mem_address) begin
          $error("mem_address: expected 0x%05h, got 0x%05h", head.mem_address, mem_address);
          mismatches++;
        end
        if (mem_write !== head.mem_write) begin
          $error("mem_write: expected %0d, got %0d", head.mem_write, mem_write);
          mismatches++;
        end
        if (bus_data !== head.bus_data) begin
          $error("bus_data: expected 0x%02h, got 0x%02h", head.bus_data, bus_data);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    int goal;
    int r;
    plan = '{
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_TICK, 16'h0000, 8'h00, 0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0, 8'h00}},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_SPARE_HI, 16'hffff, 8'hff, 0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0, 8'h00}},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_READ, 16'h0000, 8'ha5, 0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0, 8'ha5}},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_READ, 16'hffff, 8'h00, 0, 1'b1,
        '{TGT_PRG_ROM, 19'h3ffff, 1'b0, 8'h00}},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_READ, 16'h6000, 8'h5a, 0, 1'b1,
        '{TGT_PRG_RAM, 19'h0, 1'b0, 8'h00}},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'h7fff, 8'hff, 0, 1'b1,
        '{TGT_PRG_RAM, 19'h1fff, 1'b1, 8'hff}},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_PPU_READ, 16'h0000, 8'h3c, 0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0, 8'h3c}},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_PPU_WRITE, 16'h1fff, 8'hff, 0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0, 8'hff}},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_PPU_WRITE, 16'h3fff, 8'h81, 0, 1'b1,
        '{TGT_NT_RAM, 19'h3ff, 1'b1, 8'h81}},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'h8000, 8'h80, 0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0, 8'h80}},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'he000, 8'h01, 2, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0, 8'h01}},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'hffff, 8'h7f, 2, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'hffff, 8'h7f, 2, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'hffff, 8'h7f, 2, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'hffff, 8'h7f, 2, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'hffff, 8'h7f, 2, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_READ, 16'h6000, 8'h77, 0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0, 8'h00}},
      '{ROW_CFG, CFG_BOARD_KIND, FUNC_TICK, 16'h0000, {5'b0, KIND_SNROM}, 0, 1'b0, NO_RESULT},
      '{ROW_CFG, CFG_HAS_CHR_RAM, FUNC_TICK, 16'h0000, 8'h01, 0, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'ha000, 8'h00, 2, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'ha000, 8'h00, 2, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'ha000, 8'h00, 2, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'ha000, 8'h00, 2, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_WRITE, 16'ha000, 8'h01, 2, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_READ, 16'h7000, 8'h99, 0, 1'b1,
        '{TGT_NONE, 19'h0, 1'b0, 8'h99}},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_PPU_READ, 16'h1000, 8'h00, 0, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_PPU_WRITE, 16'h0abc, 8'h42, 0, 1'b0, NO_RESULT},
      '{ROW_CFG, CFG_BOARD_KIND, FUNC_TICK, 16'h0000, {5'b0, KIND_SXROM}, 0, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_CPU_READ, 16'h8000, 8'h00, 0, 1'b0, NO_RESULT},
      '{ROW_CFG, CFG_HAS_CHR_ROM, FUNC_TICK, 16'h0000, 8'h01, 0, 1'b0, NO_RESULT},
      '{ROW_ACCESS, CFG_BOARD_KIND, FUNC_PPU_READ, 16'h0fff, 8'h00, 0, 1'b0, NO_RESULT}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        set_reg(plan[i].reg_idx, plan[i].data[2:0]);
      end else begin
        issue(plan[i].func, plan[i].addr, plan[i].data, plan[i].known, plan[i].want);
        tick_pad(plan[i].pad);
      end
    end

    for (phase = 0; phase < $size(BOARDS); phase++) begin
      drain();
      set_reg(CFG_BOARD_KIND, BOARDS[phase].board_kind);
      set_reg(CFG_HAS_CHR_ROM, {2'b0, BOARDS[phase].has_chr_rom});
      set_reg(CFG_HAS_CHR_RAM, {2'b0, BOARDS[phase].has_chr_ram});
      goal = bus_items + PHASE_ITEMS;
      while (bus_items < goal) begin
        r = $urandom_range(0, 99);
        if (r < 30) serial_load();
        else if (r < 75) random_access();
        else if (r < 82) issue(FUNC_CPU_WRITE, 16'h8000 | 16'($urandom), 8'($urandom));
        else if (r < 94) tick_pad($urandom_range(1, 3));
        else issue(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), 16'($urandom),
                   8'($urandom));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[serial_bank_mapper.f]
sv/sbm_pkg.sv
sv/sbm_front.sv
sv/sbm_queue.sv
sv/sbm_back.sv
sv/serial_bank_mapper.sv
tb/tb_serial_bank_mapper.sv
